/* rtl/core/sacl_pkg.sv */
`timescale 1ns / 1ps
package sacl_pkg;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 1;
  localparam logic [CfgIdxW-1:0] CFG_REPL_MODE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_WB_EN = 1'b1;
  localparam int unsigned AddrInW = 48;
  localparam int unsigned WayOutW = 3;
  localparam int unsigned EvBlkW = 42;
  localparam int unsigned CntW = 32;
  localparam logic [CntW-1:0] CntMax = '1;
endpackage

/* rtl/core/sacl_ram.sv */
`timescale 1ns / 1ps
module sacl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/core/set_assoc_cache_lookup_unit.sv */
`timescale 1ns / 1ps
// Set-associative tag lookup. Each item (opcode_i, address_i) is taken when start_i is high
// and busy_o is low. As it is taken the whole set is read (tags, valid, dirty, age ranks
// of all ways, one memory word per set); the look-up state then compares, picks a victim
// and writes the set back. The result is registered in that state and appears for one
// cycle with done_o; the receiver cannot stall it. After reset a clearing pass writes
// every set with busy_o high; configuration writes are taken at any time.
module set_assoc_cache_lookup_unit #(
  parameter int unsigned WAYS = 8,
  parameter int unsigned SETS = 64,
  parameter int unsigned BLOCK_BYTES = 64,
  parameter int unsigned ADDR_BITS = 48
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            opcode_i,
  input  logic [sacl_pkg::AddrInW-1:0]    address_i,
  input  logic                            cfg_we_i,
  input  logic [sacl_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [sacl_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic                            done_o,
  output logic                            hit_o,
  output logic [sacl_pkg::WayOutW-1:0]    way_o,
  output logic                            writeback_o,
  output logic [sacl_pkg::EvBlkW-1:0]     evicted_block_o,
  output logic [sacl_pkg::CntW-1:0]       hits_so_far_o,
  output logic [sacl_pkg::CntW-1:0]       misses_so_far_o
);
  import sacl_pkg::*;

  localparam int unsigned OffW = $clog2(BLOCK_BYTES);
  localparam int unsigned SetW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned SetBits = $clog2(SETS);
  localparam int unsigned TagW = ADDR_BITS - OffW - SetBits;
  localparam int unsigned WayW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned LineW = TagW + 2 + WayW;
  localparam int unsigned WordW = WAYS * LineW;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_LOOK = 2'd2;

  logic [1:0] state_q, state_d;
  logic [SetW:0] clr_q;
  logic repl_q, wben_q;
  logic wr_q;
  logic [SetW-1:0] set_q;
  logic [TagW-1:0] tag_q;
  logic [CntW-1:0] hcnt_q, mcnt_q;
  logic [ADDR_BITS-1:0] addr_cut;
  logic [SetW-1:0] set_in;
  logic [TagW-1:0] tag_in;

  logic ram_we;
  logic [SetW-1:0] ram_waddr;
  logic [WordW-1:0] ram_wdata, rdata;

  logic [TagW-1:0] tg [WAYS];
  logic vl [WAYS], dt [WAYS];
  logic [WayW-1:0] rk [WAYS];
  logic [WordW-1:0] new_word, clr_word;
  logic hit;
  logic [WayW-1:0] hway, iway, oway, sel;
  logic ifound, evict_dirty;
  logic [WayW-1:0] best;

  assign addr_cut = address_i[ADDR_BITS-1:0];
  assign set_in = (SETS > 1) ? SetW'(addr_cut[OffW +: SetW]) : '0;
  assign tag_in = addr_cut[ADDR_BITS-1 -: TagW];

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      tg[w] = rdata[w*LineW + 2 + WayW +: TagW];
      vl[w] = rdata[w*LineW + 1 + WayW];
      dt[w] = rdata[w*LineW + WayW];
      rk[w] = rdata[w*LineW +: WayW];
      clr_word[w*LineW +: LineW] = {{TagW{1'b0}}, 2'b00, WayW'(w)};
    end
  end

  // search: first hit, first invalid, oldest rank (lowest way wins ties)
  always_comb begin
    hit = 1'b0; hway = '0; ifound = 1'b0; iway = '0; oway = '0; best = rk[0];
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (vl[w] && tg[w] == tag_q) begin
        hit = 1'b1; hway = WayW'(w);
      end
      if (!vl[w]) begin
        ifound = 1'b1; iway = WayW'(w);
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (rk[w] > best) begin
        best = rk[w]; oway = WayW'(w);
      end
    end
    sel = hit ? hway : (ifound ? iway : oway);
    evict_dirty = !hit && !ifound && dt[sel];
  end

  always_comb begin
    logic promote;
    promote = !hit || !repl_q;
    new_word = rdata;
    for (int w = 0; w < WAYS; w++) begin
      if (promote && rk[w] < rk[sel]) begin
        new_word[w*LineW +: WayW] = rk[w] + 1'b1;
      end
      if (WayW'(w) == sel) begin
        if (promote) new_word[w*LineW +: WayW] = '0;
        if (hit) begin
          if (wr_q && wben_q) new_word[w*LineW + WayW] = 1'b1;
        end else begin
          new_word[w*LineW + WayW +: 2 + TagW] = {tag_q, 1'b1, wr_q && wben_q};
        end
      end
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign ram_we = (state_q == ST_CLEAR) || (state_q == ST_LOOK);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_q[SetW-1:0] : set_q;
  assign ram_wdata = (state_q == ST_CLEAR) ? clr_word : new_word;

  sacl_ram #(.Width(WordW), .Depth(1 << SetW)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(set_in), .rdata_o(rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == (SetW+1)'(SETS - 1)) state_d = ST_IDLE;
      ST_IDLE: if (start_i) state_d = ST_LOOK;
      ST_LOOK: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; clr_q <= '0; repl_q <= 1'b0; wben_q <= 1'b1;
      hcnt_q <= '0; mcnt_q <= '0; done_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_REPL_MODE) repl_q <= cfg_data_i[0];
        if (cfg_idx_i == CFG_WB_EN) wben_q <= cfg_data_i[0];
      end
      done_o <= (state_q == ST_LOOK);
      if (state_q == ST_LOOK) begin
        if (hit && hcnt_q != CntMax) hcnt_q <= hcnt_q + 1'b1;
        if (!hit && mcnt_q != CntMax) mcnt_q <= mcnt_q + 1'b1;
      end
    end
  end

  assign hits_so_far_o = hcnt_q;
  assign misses_so_far_o = mcnt_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      wr_q <= opcode_i; set_q <= set_in; tag_q <= tag_in;
    end
    if (state_q == ST_LOOK) begin
      hit_o <= hit;
      way_o <= WayOutW'(sel);
      writeback_o <= evict_dirty;
      evicted_block_o <= evict_dirty
        ? EvBlkW'({tg[sel], set_q[SetBits > 0 ? SetBits-1 : 0:0]} >> (SetBits == 0))
        : '0;
    end
  end

`ifndef SYNTHESIS
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOK) |=> done_o) else $error("done missing");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("done without item");
  a_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> !writeback_o) else $error("writeback on hit");
`endif
endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
module tb;
  import sacl_pkg::*;

  localparam int unsigned NumWays = 8;
  localparam int unsigned NumSets = 64;
  localparam int unsigned TagW    = 36;
  localparam int unsigned WdLimit = 2000;

  typedef struct packed {
    logic              hit;
    logic [WayOutW-1:0] way;
    logic              wb;
    logic [EvBlkW-1:0] ev;
    logic [CntW-1:0]   hits;
    logic [CntW-1:0]   misses;
  } lookup_res_t;

  typedef struct {
    logic        op;
    logic [47:0] addr;
    bit          chk;   // typed expectation below is valid
    logic        hit;
    logic [2:0]  way;
    logic        wb;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                opcode_i = 1'b0;
  logic [AddrInW-1:0]  address_i = '0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                busy_o, done_o, hit_o, writeback_o;
  logic [WayOutW-1:0]  way_o;
  logic [EvBlkW-1:0]   evicted_block_o;
  logic [CntW-1:0]     hits_so_far_o, misses_so_far_o;

  set_assoc_cache_lookup_unit i_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the tag store and replacement state
  logic [TagW-1:0] tag_mem [NumSets][NumWays];
  bit              line_valid [NumSets][NumWays];
  bit              line_dirty [NumSets][NumWays];
  logic [2:0]      line_rank [NumSets][NumWays];
  logic [CntW-1:0] hit_cnt, miss_cnt;
  bit              fifo_mode, wb_en;

  lookup_res_t lookup_q [$];
  int          n_mismatch;
  int          n_results;
  int          idle_cnt;
  dir_row_t    dir_tbl [$];

  // Move way w to rank 0; ways younger than its old rank age by one
  function automatic void make_youngest(int s, int w);
    logic [2:0] old;
    old = line_rank[s][w];
    for (int i = 0; i < NumWays; i++)
      if (line_rank[s][i] < old) line_rank[s][i]++;
    line_rank[s][w] = '0;
  endfunction

  function automatic lookup_res_t lookup_access(logic wr, logic [47:0] addr);
    lookup_res_t r;
    logic [41:0] blk;
    logic [TagW-1:0] tg;
    int s, w;
    bit found;
    blk = addr[47:6];
    s = blk[5:0];
    tg = blk[41:6];
    r = '0;
    w = 0;
    found = 0;
    for (int i = 0; i < NumWays; i++)
      if (!found && line_valid[s][i] && tag_mem[s][i] == tg) begin
        found = 1;
        w = i;
      end
    if (found) begin
      r.hit = 1'b1;
      if (hit_cnt != CntMax) hit_cnt++;
      if (wr && wb_en) line_dirty[s][w] = 1;
      if (!fifo_mode) make_youngest(s, w);
    end else begin
      if (miss_cnt != CntMax) miss_cnt++;
      // Prefer the lowest invalid way, else the oldest (lowest way on tie)
      for (int i = 0; i < NumWays; i++)
        if (!found && !line_valid[s][i]) begin
          found = 1;
          w = i;
        end
      if (!found) begin
        w = 0;
        for (int i = 1; i < NumWays; i++)
          if (line_rank[s][i] > line_rank[s][w]) w = i;
        if (line_dirty[s][w]) begin
          r.wb = 1'b1;
          r.ev = {tag_mem[s][w], 6'(s)};
        end
      end
      tag_mem[s][w] = tg;
      line_valid[s][w] = 1;
      line_dirty[s][w] = wr && wb_en;
      make_youngest(s, w);
    end
    r.way = w[2:0];
    r.hits = hit_cnt;
    r.misses = miss_cnt;
    return r;
  endfunction

  // Monitor: predict on each accepted item, check each strobed result
  always @(posedge clk_i) begin
    lookup_res_t exp_r, act_r;
    int idle_nxt;
    if (rst_ni) begin
      idle_nxt = idle_cnt + 1;
      if (start_i && !busy_o) begin
        lookup_q.push_back(lookup_access(opcode_i, address_i));
        idle_nxt = 0;
      end
      if (done_o) begin
        idle_nxt = 0;
        act_r = '{hit_o, way_o, writeback_o, evicted_block_o, hits_so_far_o,
                  misses_so_far_o};
        if (lookup_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected result %h", act_r);
        end else begin
          exp_r = lookup_q.pop_front();
          // Directed rows also carry hand-typed values
          if (n_results < dir_tbl.size() && dir_tbl[n_results].chk) begin
            exp_r.hit = dir_tbl[n_results].hit;
            exp_r.way = dir_tbl[n_results].way;
            exp_r.wb  = dir_tbl[n_results].wb;
          end
          if (act_r !== exp_r) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("result %0d: expected %h got %h", n_results, exp_r, act_r);
          end
        end
        n_results++;
      end
      idle_cnt <= idle_nxt;
    end
  end

  // Watchdog: too long without any accepted item or result
  always @(posedge clk_i) begin
    if (idle_cnt >= WdLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Idle the given share of cycles, then hold the item until the block takes it
  task automatic send_item(logic op, logic [47:0] addr, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    opcode_i <= op;
    address_i <= addr;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Drain outstanding lookups, then write one register
  task automatic write_cfg(logic [CfgIdxW-1:0] idx, bit val);
    start_i <= 1'b0;
    while (lookup_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_REPL_MODE) fifo_mode = val;
    else wb_en = val;
  endtask

  function automatic logic [47:0] rand_addr();
    // Mostly a small pool of sets and tags so hits and evictions are common
    if ($urandom_range(99) < 80)
      return {36'($urandom_range(11)), 6'($urandom_range(3)), 6'($urandom)};
    return {16'($urandom), 32'($urandom)};
  endfunction

  initial begin
    bit repl_seq [6] = '{0, 1, 0, 1, 1, 0};
    bit wb_seq [6]   = '{1, 1, 0, 0, 1, 1};
    for (int s = 0; s < NumSets; s++)
      for (int w = 0; w < NumWays; w++) begin
        line_valid[s][w] = 0;
        line_dirty[s][w] = 0;
        line_rank[s][w] = w[2:0];
      end
    hit_cnt = '0;
    miss_cnt = '0;
    fifo_mode = 0;
    wb_en = 1;
    n_mismatch = 0;
    n_results = 0;
    idle_cnt = 0;

    // Directed: first miss after reset, write hit, fill set 0, evict dirty
    // oldest line, address extremes and offset-only differences
    dir_tbl.push_back('{0, 48'h0, 1, 0, 0, 0});
    dir_tbl.push_back('{1, 48'h3f, 1, 1, 0, 0});
    for (int k = 1; k < 8; k++)
      dir_tbl.push_back('{1, 48'(k) << 12, 1, 0, 3'(k), 0});
    dir_tbl.push_back('{0, 48'h8000, 1, 0, 0, 1});
    dir_tbl.push_back('{1, 48'hffff_ffff_ffff, 1, 0, 0, 0});
    dir_tbl.push_back('{0, 48'hffff_ffff_ffc0, 1, 1, 0, 0});
    dir_tbl.push_back('{0, 48'h7fff_ffff_ffc0, 0, 0, 0, 0});
    dir_tbl.push_back('{1, 48'h1000, 0, 0, 0, 0});
    dir_tbl.push_back('{0, 48'h9000, 0, 0, 0, 0});
    dir_tbl.push_back('{1, 48'ha000, 0, 0, 0, 0});
    dir_tbl.push_back('{0, 48'h2000, 0, 0, 0, 0});
    dir_tbl.push_back('{1, 48'h5555_5555_5555, 0, 0, 0, 0});
    dir_tbl.push_back('{0, 48'haaaa_aaaa_aaaa, 0, 0, 0, 0});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_cfg(CFG_REPL_MODE, 0);
    write_cfg(CFG_WB_EN, 1);
    foreach (dir_tbl[i]) send_item(dir_tbl[i].op, dir_tbl[i].addr, 0);

    // Random phases: walk the register settings and the idle schedule
    for (int p = 0; p < 6; p++) begin
      write_cfg(CFG_REPL_MODE, repl_seq[p]);
      write_cfg(CFG_WB_EN, wb_seq[p]);
      for (int n = 0; n < 100; n++)
        send_item(1'($urandom), rand_addr(), (p < 2) ? 26 : (p < 4) ? 68 : 0);
    end
    start_i <= 1'b0;

    while (lookup_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
